// File: hdl/chv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chv_pkg
// shared types, codes and constants of the chunk hash verify table
// ----------------------------------------------------------------------------
package chv_pkg;

	localparam int          MAX_CHUNKS_DEF = 256;
	localparam logic [63:0] FNV_BASIS      = 64'hCBF2_9CE4_8422_2325;

	localparam logic [31:0] MAIN_RAM_SIZE_RST = 32'd25165824;
	localparam logic [31:0] CACHED_BASE_RST   = 32'h8000_0000;
	localparam logic [31:0] UNCACHED_BASE_RST = 32'hC000_0000;
	localparam logic [31:0] RAM_BYTES_RST     = 32'd25165824;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_BYTE  = 2'd2,
		REQ_INVAL = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STAT_NO     = 3'd0,
		STAT_YES    = 3'd1,
		STAT_SEND   = 3'd2,
		STAT_BUSY   = 3'd3,
		STAT_ACCEPT = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		VS_UNVERIFIED = 2'd0,
		VS_VERIFIED   = 2'd1,
		VS_FAILED     = 2'd2
	} vstate_t;

	typedef enum logic [2:0] {
		REG_MAIN_RAM_SIZE = 3'd0,
		REG_CACHED_BASE   = 3'd1,
		REG_UNCACHED_BASE = 3'd2,
		REG_RAM_BYTES     = 3'd3,
		REG_RAM_PRESENT   = 3'd4,
		REG_CHUNK_COUNT   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] start_addr;
		logic [31:0] end_addr;
		logic [63:0] hash;
	} entry_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] canon;
	} canon_t;

	function automatic canon_t to_canon(input logic [31:0] a, input logic [31:0] mrs,
			input logic [31:0] cb, input logic [31:0] ub);
		canon_t r;
		logic [32:0] a33;
		r.ok    = 1'b1;
		r.canon = a | cb;
		a33     = {1'b0, a};
		if (a33 < {1'b0, mrs}) begin
			r.canon = a | cb;
		end else if (a >= cb && a33 < ({1'b0, cb} + {1'b0, mrs})) begin
			r.canon = a;
		end else if (a >= ub && a33 < ({1'b0, ub} + {1'b0, mrs})) begin
			r.canon = (a - ub) | cb;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: hdl/chunk_hash_verify_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_hash_verify_table
// sorted chunk table with address mapping, binary search and hash check
// ----------------------------------------------------------------------------
// One item at a time goes through a small sequencer around a table memory
// with one registered read port and separate write ports, so item time
// follows the number of table reads: a load reads the old verify state of
// its slot, a ram byte reads the pending entry on the last byte of a chunk,
// a query reads one entry per binary-search step (256 chunks need at most
// nine steps), and an invalidate reads each entry it walks until one starts
// at or past the end of the range or the table ends. After reset the block
// clears the verify states of all table slots before it takes its first
// item; register writes are taken throughout. A result waits in the output
// register while the next item is already at work; an item that finishes
// while that register is still full waits until the earlier result is
// taken.
module chunk_hash_verify_table import chv_pkg::*; #(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] address,
	input  logic [31:0] range_size,
	input  logic [7:0]  entry_index,
	input  logic [31:0] chunk_start,
	input  logic [31:0] chunk_end,
	input  logic [63:0] chunk_hash,
	input  logic [7:0]  ram_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        chunk_found,
	output logic [7:0]  chunk_slot,
	output logic [31:0] ram_offset,
	output logic [31:0] ram_length,
	output logic [31:0] verification_count,
	output logic [31:0] verified_count,
	output logic [31:0] failed_count,
	output logic [31:0] invalidation_count
);

	localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int CW = $clog2(MAX_CHUNKS + 1);

	typedef enum logic [12:0] {
		S_CLEAR = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_MAP   = 13'b0000000000100,
		S_SRD   = 13'b0000000001000,
		S_SCMP  = 13'b0000000010000,
		S_CHK   = 13'b0000000100000,
		S_LWR   = 13'b0000001000000,
		S_HASH  = 13'b0000010000000,
		S_FIN   = 13'b0000100000000,
		S_IRD   = 13'b0001000000000,
		S_IEV   = 13'b0010000000000,
		S_RESP  = 13'b0100000000000,
		S_SPARE = 13'b1000000000000
	} fsm_t;

	fsm_t        state_q;
	logic [31:0] main_ram_size_q, cached_base_q, uncached_base_q, ram_bytes_q;
	logic        ram_present_q;
	logic [8:0]  chunk_count_q;

	logic [31:0] verif_q, verified_q, failed_q, inval_q;
	logic        checking_q;
	logic [IW-1:0] pending_q;
	logic [31:0] bytes_left_q;

	logic [IW-1:0] clr_q, eidx_q, slot_q;
	logic [CW-1:0] lo_q, hi_q, mid_q, idx_q;
	logic [1:0]  type_q;
	logic [31:0] addr_q, size_q, canon_q, off_q, len_q;
	logic [32:0] rend_q;
	logic [7:0]  byte_q;

	status_t     res_status_q;
	logic        res_found_q;
	logic [31:0] res_off_q, res_len_q;

	logic        out_valid_q, out_found_q;
	status_t     out_status_q;
	logic [7:0]  out_slot_q;
	logic [31:0] out_off_q, out_len_q, out_verif_q, out_verified_q, out_failed_q, out_inval_q;

	logic          acc, cfg_wr, eidx_ok, last_byte, fnv_init, fnv_step, match;
	logic [CW-1:0] live, mid;
	canon_t        cmap;
	logic          rd_en, ent_we, st_we;
	logic [IW-1:0] rd_addr, st_wa;
	vstate_t       st_wd, rd_state;
	entry_t        ent_wd, rd_entry;
	logic [63:0]   fnv_hash;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;
	assign eidx_ok  = {24'd0, entry_index} < 32'(MAX_CHUNKS);
	assign live     = ({23'd0, chunk_count_q} > 32'(MAX_CHUNKS)) ? CW'(MAX_CHUNKS)
			: CW'(chunk_count_q);
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign cmap      = to_canon(addr_q, main_ram_size_q, cached_base_q, uncached_base_q);
	assign last_byte = (bytes_left_q == 32'd1);
	assign match     = (fnv_hash == rd_entry.hash);
	assign ent_wd    = '{start_addr: chunk_start, end_addr: chunk_end, hash: chunk_hash};
	assign fnv_step  = (state_q == S_HASH);
	assign fnv_init  = (state_q == S_CHK);

	always_comb begin
		case (paddr[4:2])
			REG_MAIN_RAM_SIZE: prdata = main_ram_size_q;
			REG_CACHED_BASE:   prdata = cached_base_q;
			REG_UNCACHED_BASE: prdata = uncached_base_q;
			REG_RAM_BYTES:     prdata = ram_bytes_q;
			REG_RAM_PRESENT:   prdata = {31'd0, ram_present_q};
			REG_CHUNK_COUNT:   prdata = {23'd0, chunk_count_q};
			default:           prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_ram_size_q <= MAIN_RAM_SIZE_RST;
			cached_base_q   <= CACHED_BASE_RST;
			uncached_base_q <= UNCACHED_BASE_RST;
			ram_bytes_q     <= RAM_BYTES_RST;
			ram_present_q   <= 1'b1;
			chunk_count_q   <= 9'd0;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_MAIN_RAM_SIZE: main_ram_size_q <= pwdata;
				REG_CACHED_BASE:   cached_base_q   <= pwdata;
				REG_UNCACHED_BASE: uncached_base_q <= pwdata;
				REG_RAM_BYTES:     ram_bytes_q     <= pwdata;
				REG_RAM_PRESENT:   ram_present_q   <= pwdata[0];
				REG_CHUNK_COUNT:   chunk_count_q   <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	// table port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = slot_q;
		ent_we  = 1'b0;
		st_we   = 1'b0;
		st_wa   = slot_q;
		st_wd   = VS_UNVERIFIED;
		case (state_q)
			S_CLEAR: begin
				st_we = 1'b1;
				st_wa = clr_q;
			end
			S_IDLE: begin
				rd_addr = IW'(entry_index);
				if (acc && req_type == REQ_LOAD && !checking_q && eidx_ok) begin
					rd_en  = 1'b1;
					ent_we = 1'b1;
				end
			end
			S_SRD: begin
				rd_addr = mid[IW-1:0];
				rd_en   = (lo_q < hi_q);
			end
			S_CHK: begin
				st_wd = VS_FAILED;
				st_we = (rd_entry.start_addr < cached_base_q) || (off_q >= ram_bytes_q)
						|| (len_q > ram_bytes_q - off_q);
			end
			S_LWR: begin
				st_we = 1'b1;
				st_wa = eidx_q;
			end
			S_HASH: begin
				rd_addr = pending_q;
				rd_en   = last_byte;
			end
			S_FIN: begin
				st_we = 1'b1;
				st_wd = match ? VS_VERIFIED : VS_FAILED;
			end
			S_IRD: begin
				rd_addr = idx_q[IW-1:0];
				rd_en   = (idx_q < live);
			end
			S_IEV: begin
				st_wa = idx_q[IW-1:0];
				st_we = (rd_entry.end_addr > canon_q)
						&& ({1'b0, rd_entry.start_addr} < rend_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			verif_q      <= 32'd0;
			verified_q   <= 32'd0;
			failed_q     <= 32'd0;
			inval_q      <= 32'd0;
			checking_q   <= 1'b0;
			pending_q    <= '0;
			bytes_left_q <= 32'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(MAX_CHUNKS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						res_status_q <= STAT_ACCEPT;
						res_found_q  <= 1'b0;
						slot_q       <= '0;
						res_off_q    <= 32'd0;
						res_len_q    <= 32'd0;
						type_q       <= req_type;
						addr_q       <= address;
						size_q       <= range_size;
						eidx_q       <= IW'(entry_index);
						byte_q       <= ram_byte;
						if (req_type == REQ_BYTE) begin
							if (checking_q) begin
								state_q <= S_HASH;
							end else begin
								res_status_q <= STAT_BUSY;
								state_q      <= S_RESP;
							end
						end else if (checking_q) begin
							res_status_q <= STAT_BUSY;
							state_q      <= S_RESP;
						end else if (req_type == REQ_LOAD) begin
							state_q <= eidx_ok ? S_LWR : S_RESP;
						end else begin
							state_q <= S_MAP;
						end
					end
				end
				S_MAP: begin
					canon_q <= cmap.canon;
					rend_q  <= {1'b0, cmap.canon} + {1'b0, size_q};
					lo_q    <= '0;
					hi_q    <= live;
					idx_q   <= '0;
					if (type_q == REQ_QUERY) begin
						res_status_q <= STAT_NO;
						state_q <= (ram_present_q && cmap.ok) ? S_SRD : S_RESP;
					end else begin
						state_q <= (size_q != 32'd0 && cmap.ok) ? S_IRD : S_RESP;
					end
				end
				S_SRD: begin
					mid_q   <= mid;
					state_q <= (lo_q < hi_q) ? S_SCMP : S_RESP;
				end
				S_SCMP: begin
					if (canon_q < rd_entry.start_addr) begin
						hi_q    <= mid_q;
						state_q <= S_SRD;
					end else if (canon_q >= rd_entry.end_addr) begin
						lo_q    <= mid_q + 1'b1;
						state_q <= S_SRD;
					end else begin
						res_found_q <= 1'b1;
						slot_q      <= mid_q[IW-1:0];
						off_q       <= rd_entry.start_addr - cached_base_q;
						len_q       <= rd_entry.end_addr - rd_entry.start_addr;
						state_q     <= S_RESP;
						if (rd_state == VS_VERIFIED) begin
							res_status_q <= STAT_YES;
						end else if (rd_state == VS_UNVERIFIED) begin
							verif_q <= verif_q + 32'd1;
							state_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					if (st_we) begin
						failed_q <= failed_q + 32'd1;
						state_q  <= S_RESP;
					end else if (len_q == 32'd0) begin
						state_q <= S_FIN;
					end else begin
						checking_q   <= 1'b1;
						pending_q    <= slot_q;
						bytes_left_q <= len_q;
						res_off_q    <= off_q;
						res_len_q    <= len_q;
						res_status_q <= STAT_SEND;
						state_q      <= S_RESP;
					end
				end
				S_LWR: begin
					if (rd_state == VS_VERIFIED) begin
						verified_q <= verified_q - 32'd1;
					end else if (rd_state == VS_FAILED) begin
						failed_q <= failed_q - 32'd1;
					end
					state_q <= S_RESP;
				end
				S_HASH: begin
					bytes_left_q <= bytes_left_q - 32'd1;
					if (last_byte) begin
						checking_q  <= 1'b0;
						slot_q      <= pending_q;
						res_found_q <= 1'b1;
						state_q     <= S_FIN;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_FIN: begin
					if (match) begin
						verified_q   <= verified_q + 32'd1;
						res_status_q <= STAT_YES;
					end else begin
						failed_q     <= failed_q + 32'd1;
						res_status_q <= STAT_NO;
					end
					state_q <= S_RESP;
				end
				S_IRD: begin
					state_q <= (idx_q < live) ? S_IEV : S_RESP;
				end
				S_IEV: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= S_IRD;
					if (rd_entry.end_addr > canon_q) begin
						if ({1'b0, rd_entry.start_addr} >= rend_q) begin
							state_q <= S_RESP;
						end else begin
							inval_q <= inval_q + 32'd1;
							if (rd_state == VS_VERIFIED) begin
								verified_q <= verified_q - 32'd1;
							end else if (rd_state == VS_FAILED) begin
								failed_q <= failed_q - 32'd1;
							end
						end
					end
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result transfer register
	always_ff @(posedge clk) begin
		if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
			out_status_q   <= res_status_q;
			out_found_q    <= res_found_q;
			out_slot_q     <= 8'(slot_q);
			out_off_q      <= res_off_q;
			out_len_q      <= res_len_q;
			out_verif_q    <= verif_q;
			out_verified_q <= verified_q;
			out_failed_q   <= failed_q;
			out_inval_q    <= inval_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = out_status_q;
	assign chunk_found        = out_found_q;
	assign chunk_slot         = out_slot_q;
	assign ram_offset         = out_off_q;
	assign ram_length         = out_len_q;
	assign verification_count = out_verif_q;
	assign verified_count     = out_verified_q;
	assign failed_count       = out_failed_q;
	assign invalidation_count = out_inval_q;

	chv_table #(
		.DEPTH (MAX_CHUNKS),
		.IW    (IW)
	) u_table (
		.clk      (clk),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.ent_we   (ent_we),
		.ent_wa   (IW'(entry_index)),
		.ent_wd   (ent_wd),
		.st_we    (st_we),
		.st_wa    (st_wa),
		.st_wd    (st_wd),
		.rd_entry (rd_entry),
		.rd_state (rd_state)
	);

	chv_fnv u_fnv (
		.clk     (clk),
		.arst_n  (arst_n),
		.init    (fnv_init),
		.step    (fnv_step),
		.data_in (byte_q),
		.hash    (fnv_hash)
	);

endmodule

// File: hdl/chv_fnv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chv_fnv
// running fnv-1a 64 hash, one byte per step
// ----------------------------------------------------------------------------
module chv_fnv import chv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        init,
	input  logic        step,
	input  logic [7:0]  data_in,
	output logic [63:0] hash
);

	logic [63:0] hash_q;
	logic [63:0] x;
	logic [63:0] next_hash;

	// multiply by 2^40 + 0x1b3 as shifts and adds
	always_comb begin
		x         = hash_q ^ {56'd0, data_in};
		next_hash = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
		end else if (init) begin
			hash_q <= FNV_BASIS;
		end else if (step) begin
			hash_q <= next_hash;
		end
	end

	assign hash = hash_q;

endmodule

// File: hdl/chv_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chv_table
// chunk entry memory and verify state memory, registered reads
// ----------------------------------------------------------------------------
module chv_table import chv_pkg::*; #(
	parameter int DEPTH = MAX_CHUNKS_DEF,
	parameter int IW    = 8
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	input  logic          ent_we,
	input  logic [IW-1:0] ent_wa,
	input  entry_t        ent_wd,
	input  logic          st_we,
	input  logic [IW-1:0] st_wa,
	input  vstate_t       st_wd,
	output entry_t        rd_entry,
	output vstate_t       rd_state
);

	entry_t  entry_mem [DEPTH];
	vstate_t state_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ent_we) begin
			entry_mem[ent_wa] <= ent_wd;
		end
		if (rd_en) begin
			rd_entry <= entry_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			state_mem[st_wa] <= st_wd;
		end
		if (rd_en) begin
			rd_state <= state_mem[rd_addr];
		end
	end

endmodule

// File: hdl/chv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chv_checker
// port-level checks of the chunk hash verify table
// ----------------------------------------------------------------------------
module chv_checker import chv_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic        chunk_found,
	input logic [31:0] ram_length
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result changed while stalled");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after a transfer");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= STAT_ACCEPT)
		else $error("status code out of range");

	a_send_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_SEND |-> chunk_found && ram_length != 32'd0)
		else $error("send request without chunk or length");

	a_busy_nofound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_BUSY |-> !chunk_found)
		else $error("busy answer names a chunk");

endmodule

bind chunk_hash_verify_table chv_checker u_chv_checker (.*);
